FILE: design/csfd_pkg.sv
package csfd_pkg;

  localparam int unsigned RING_DEPTH  = 524288;
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned POS_W      = $clog2(RING_DEPTH);
  localparam int unsigned LANE_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned FRAC_W     = 5;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned BEAT_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned FRAC_MAX          = 16;
  localparam int unsigned FRAC_RESET        = 8;
  localparam int unsigned RING_LENGTH_RESET = 441001;
  localparam int unsigned INIT_BEAT_RESET   = 22050;
  localparam int          TRIG_HIGH_RESET   = 3277;
  localparam int          TRIG_LOW_RESET    = 328;

  // shortest beat: round((ring_length - 1) / 100000)
  localparam int unsigned MIN_BEAT_DIV  = 100000;
  localparam int unsigned MIN_BEAT_HALF = 50000;
  localparam int unsigned MINB_MAX      = (RING_DEPTH - 1 + MIN_BEAT_HALF) / MIN_BEAT_DIV;
  localparam int unsigned MINB_W        = $clog2(MINB_MAX + 2);

  localparam int unsigned RL_M1_RESET =
    ((RING_LENGTH_RESET > RING_DEPTH) ? RING_DEPTH : RING_LENGTH_RESET) - 1;
  localparam int unsigned MINB_RESET  = (RL_M1_RESET + MIN_BEAT_HALF) / MIN_BEAT_DIV;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRACTION     = 3'd0,
    REG_RING_LENGTH  = 3'd1,
    REG_INITIAL_BEAT = 3'd2,
    REG_TRIG_HIGH    = 3'd3,
    REG_TRIG_LOW     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [FRAC_W-1:0]        fraction;
    logic [POS_W-1:0]         rl_m1;
    logic [MINB_W-1:0]        min_beat;
    logic signed [VOLT_W-1:0] trig_high;
    logic signed [VOLT_W-1:0] trig_low;
    logic                     wp_clear;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [VOLT_W-1:0] sample;
    logic [CH_W-1:0]          channel;
    logic                     frame_last;
    logic [POS_W-1:0]         delay;
  } ring_req_t;

endpackage

FILE: design/csfd_intf.sv
interface csfd_item_if import csfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] clock_level;
  logic signed [VOLT_W-1:0] sample_in;
  logic [CH_W-1:0]          channel;
  logic                     frame_last;

  modport source(output valid, clock_level, sample_in, channel, frame_last, input ready);
  modport sink(input valid, clock_level, sample_in, channel, frame_last, output ready);
endinterface

interface csfd_result_if import csfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] delayed_sample;
  logic [CH_W-1:0]          channel_out;

  modport source(output valid, delayed_sample, channel_out, input ready);
  modport sink(input valid, delayed_sample, channel_out, output ready);
endinterface

interface csfd_cfg_if import csfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/clock_synced_fraction_delay.sv
// Tempo-synced delay for up to 16 channels, one item per clock cycle unless the
// result side stalls or the memory clear runs. Each item carries one channel's
// sample; a frame runs channel 0 upward and its last item advances the shared
// write position. Channel-0 items also sample the clock input through a Schmitt
// trigger and retune the delay to a number of sixteenths of the measured beat.
// The pipeline is a tempo stage, a 24x5 multiply stage and one access to a single
// memory of 524288 rows (one 16-bit lane per channel) with one write and one read
// port, each stage registered. After reset the memory is zeroed one row per cycle
// and no item is taken meanwhile; configuration writes are taken at any time.
module clock_synced_fraction_delay import csfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  csfd_cfg_if.sink      cfg_i,
  csfd_item_if.sink     item_i,
  csfd_result_if.source result_o
);

  cfg_t      cfg;
  ring_req_t req;
  logic      req_ready;
  logic      clearing;

  csfd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  csfd_tempo u_tempo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .hold_i      (clearing),
    .item_i      (item_i),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  csfd_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req),
    .req_ready_o (req_ready),
    .clearing_o  (clearing),
    .result_o    (result_o)
  );

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !result_o.valid && !req.valid)
    else $error("item in flight during memory clear");

  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(req.valid))
    else $error("result without a memory request");

  a_clear_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing) |-> !result_o.valid)
    else $error("result present as memory clear ends");

endmodule

FILE: design/csfd_cfg.sv
module csfd_cfg import csfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  csfd_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  logic [FRAC_W-1:0]        frac_q, frac_d;
  logic [POS_W-1:0]         rl_m1_q, rl_m1_d;
  logic [MINB_W-1:0]        minb_q, minb_d;
  logic signed [VOLT_W-1:0] hi_q, lo_q;
  logic [LEN_W-1:0]         len;
  logic [FRAC_W-1:0]        frac_in;
  logic                     wr_frac, wr_len, wr_hi, wr_lo;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    wr_frac = 1'b0;
    wr_len  = 1'b0;
    wr_hi   = 1'b0;
    wr_lo   = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_FRACTION:     wr_frac = 1'b1;
        REG_RING_LENGTH:  wr_len  = 1'b1;
        // initial beat only matters at reset, which restores its default
        REG_INITIAL_BEAT: ;
        REG_TRIG_HIGH:    wr_hi   = 1'b1;
        REG_TRIG_LOW:     wr_lo   = 1'b1;
        default:          ;
      endcase
    end
  end

  always_comb begin
    frac_in = cfg_i.data[FRAC_W-1:0];
    frac_d  = (32'(frac_in) > FRAC_MAX) ? FRAC_W'(FRAC_MAX) : frac_in;

    len = cfg_i.data[LEN_W-1:0];
    if (len == '0) begin
      rl_m1_d = '0;
    end else if (32'(len) > RING_DEPTH) begin
      rl_m1_d = POS_W'(RING_DEPTH - 1);
    end else begin
      rl_m1_d = POS_W'(len - 1'b1);
    end

    minb_d = '0;
    for (int k = 1; k <= int'(MINB_MAX); k++) begin
      if (32'(rl_m1_d) + MIN_BEAT_HALF >= 32'(k) * MIN_BEAT_DIV) begin
        minb_d = MINB_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q  <= FRAC_W'(FRAC_RESET);
      rl_m1_q <= POS_W'(RL_M1_RESET);
      minb_q  <= MINB_W'(MINB_RESET);
      hi_q    <= VOLT_W'(TRIG_HIGH_RESET);
      lo_q    <= VOLT_W'(TRIG_LOW_RESET);
    end else begin
      if (wr_frac) frac_q <= frac_d;
      if (wr_len) begin
        rl_m1_q <= rl_m1_d;
        minb_q  <= minb_d;
      end
      if (wr_hi) hi_q <= cfg_i.data[VOLT_W-1:0];
      if (wr_lo) lo_q <= cfg_i.data[VOLT_W-1:0];
    end
  end

  always_comb begin
    cfg_o.fraction  = frac_q;
    cfg_o.rl_m1     = rl_m1_q;
    cfg_o.min_beat  = minb_q;
    cfg_o.trig_high = hi_q;
    cfg_o.trig_low  = lo_q;
    cfg_o.wp_clear  = wr_len;
  end

endmodule

FILE: design/csfd_tempo.sv
module csfd_tempo import csfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       hold_i,
  csfd_item_if.sink  item_i,
  output ring_req_t  req_o,
  input  logic       req_ready_i
);

  localparam int unsigned PROD_W = BEAT_W + FRAC_W;
  localparam int unsigned RND_W  = PROD_W - 4;

  logic [BEAT_W-1:0] elapsed_q, elapsed_d;
  logic [BEAT_W-1:0] beat_q, beat_d;
  logic              seen_q, seen_d;
  logic              armed_q, armed_d;
  logic [POS_W-1:0]  cur_delay_q;

  logic                     a_valid_q;
  logic signed [VOLT_W-1:0] a_sample_q;
  logic [CH_W-1:0]          a_ch_q;
  logic                     a_last_q;
  logic                     a_ch0_q;
  logic [BEAT_W-1:0]        a_beat_q;

  ring_req_t         req_q;
  logic              en_a, en_b, accept, is_ch0, fire;
  logic [BEAT_W-1:0] el_inc;
  logic [PROD_W-1:0] prod;
  logic [RND_W-1:0]  rnd;
  logic [POS_W-1:0]  new_delay;

  assign en_b         = !req_q.valid || req_ready_i;
  assign en_a         = !a_valid_q || en_b;
  assign item_i.ready = en_a && !hold_i;
  assign accept       = item_i.valid && item_i.ready;
  assign is_ch0       = (item_i.channel == '0);

  // tick, Schmitt trigger and beat measurement
  always_comb begin
    el_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    fire    = armed_q && (item_i.clock_level >= cfg_i.trig_high);
    armed_d = armed_q ? !fire : (item_i.clock_level <= cfg_i.trig_low);
    beat_d  = beat_q;
    if (fire && seen_q) begin
      beat_d = (el_inc > BEAT_W'(cfg_i.min_beat)) ? el_inc : BEAT_W'(cfg_i.min_beat);
    end
    seen_d    = seen_q || fire;
    elapsed_d = fire ? '0 : el_inc;
  end

  // delay = round(beat * fraction / 16), clamped to the ring
  always_comb begin
    prod      = PROD_W'(a_beat_q) * PROD_W'(cfg_i.fraction);
    prod      = prod + PROD_W'(8);
    rnd       = prod[PROD_W-1:4];
    new_delay = (rnd > RND_W'(cfg_i.rl_m1)) ? cfg_i.rl_m1 : rnd[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      beat_q      <= BEAT_W'(INIT_BEAT_RESET);
      seen_q      <= 1'b0;
      armed_q     <= 1'b0;
      cur_delay_q <= '0;
      a_valid_q   <= 1'b0;
      req_q       <= '0;
    end else begin
      if (accept && is_ch0) begin
        elapsed_q <= elapsed_d;
        beat_q    <= beat_d;
        seen_q    <= seen_d;
        armed_q   <= armed_d;
      end
      if (en_a) a_valid_q <= accept;
      if (en_b) begin
        req_q.valid      <= a_valid_q;
        req_q.sample     <= a_sample_q;
        req_q.channel    <= a_ch_q;
        req_q.frame_last <= a_last_q;
        req_q.delay      <= a_ch0_q ? new_delay : cur_delay_q;
      end
      if (a_valid_q && en_b && a_ch0_q) cur_delay_q <= new_delay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= item_i.sample_in;
      a_ch_q     <= item_i.channel;
      a_last_q   <= item_i.frame_last;
      a_ch0_q    <= is_ch0;
      a_beat_q   <= beat_d;
    end
  end

  assign req_o = req_q;

endmodule

FILE: design/csfd_ring.sv
module csfd_ring import csfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  ring_req_t     req_i,
  output logic          req_ready_o,
  output logic          clearing_o,
  csfd_result_if.source result_o
);

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] rd_q;
  logic                   out_valid_q;
  logic [CH_W-1:0]        ch_q;
  logic                   chok_q;
  logic                   fwd_q;
  logic [SAMPLE_BITS-1:0] fwd_data_q;
  logic [POS_W-1:0]       wp_q;
  logic                   clr_busy_q;
  logic [POS_W-1:0]       clr_addr_q;

  logic                   fire, ch_ok;
  logic [POS_W-1:0]       wp, dly, rp, waddr, wp_next;
  logic [POS_W:0]         rp_w;
  logic [CHANNELS-1:0]    we;
  logic [SAMPLE_BITS-1:0] wdata, item_word, word;

  assign req_ready_o = !out_valid_q || result_o.ready;
  assign fire        = req_i.valid && req_ready_o;
  assign clearing_o  = clr_busy_q;

  always_comb begin
    ch_ok     = (32'(req_i.channel) < CHANNELS);
    wp        = (wp_q > cfg_i.rl_m1) ? '0 : wp_q;
    dly       = (req_i.delay > cfg_i.rl_m1) ? cfg_i.rl_m1 : req_i.delay;
    if (wp >= dly) begin
      rp_w = {1'b0, wp} - {1'b0, dly};
    end else begin
      rp_w = {1'b0, wp} + {1'b0, cfg_i.rl_m1 - dly} + 1'b1;
    end
    rp        = rp_w[POS_W-1:0];
    wp_next   = (wp == cfg_i.rl_m1) ? '0 : wp + 1'b1;
    item_word = SAMPLE_BITS'(req_i.sample);

    waddr = clr_busy_q ? clr_addr_q : wp;
    wdata = clr_busy_q ? '0 : item_word;
    for (int l = 0; l < int'(CHANNELS); l++) begin
      we[l] = clr_busy_q || (fire && ch_ok && (32'(req_i.channel) == 32'(l)));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < int'(CHANNELS); l++) begin
      if (we[l]) ring_mem[waddr][l] <= wdata;
    end
    if (fire) rd_q <= ring_mem[rp];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (req_ready_o) out_valid_q <= req_i.valid;
      if (cfg_i.wp_clear) begin
        wp_q <= '0;
      end else if (fire && req_i.frame_last) begin
        wp_q <= wp_next;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == POS_W'(RING_DEPTH - 1)) clr_busy_q <= 1'b0;
      end
    end
  end

  // same-entry read and write in one cycle: the memory returns old data
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ch_q       <= req_i.channel;
      chok_q     <= ch_ok;
      fwd_q      <= (rp == wp);
      fwd_data_q <= item_word;
    end
  end

  always_comb begin
    word = fwd_q ? fwd_data_q : rd_q[ch_q[LANE_W-1:0]];
    result_o.valid          = out_valid_q;
    result_o.channel_out    = ch_q;
    result_o.delayed_sample = chok_q ? VOLT_W'(signed'(word)) : '0;
  end

endmodule

FILE: test/clock_synced_fraction_delay_checker.sv
`timescale 1ns / 1ps
module clock_synced_fraction_delay_checker import csfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  csfd_cfg_if    cfg_i,
  csfd_item_if   item_i,
  csfd_result_if result_i,
  output int     mismatches_o,
  output int     in_flight_o
);

  localparam int unsigned ELAPSED_MAX  = (1 << BEAT_W) - 1;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [VOLT_W-1:0] delayed_sample;
    logic [CH_W-1:0]          channel;
  } tap_t;

  logic [FRAC_W-1:0]        fraction;
  logic [LEN_W-1:0]         ring_length;
  logic [BEAT_W-1:0]        initial_beat;
  logic signed [VOLT_W-1:0] trig_high;
  logic signed [VOLT_W-1:0] trig_low;

  logic [VOLT_W-1:0] lanes [int unsigned];
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  cur_delay;
  logic [BEAT_W-1:0] elapsed;
  logic [BEAT_W-1:0] beat;
  bit                clock_seen;
  bit                armed_low;

  tap_t due_taps [$];
  int   reported;

  function automatic int unsigned active_length();
    if (ring_length == 0) return 1;
    if (ring_length > RING_DEPTH) return RING_DEPTH;
    return 32'(ring_length);
  endfunction

  function automatic tap_t delay_tap(input logic signed [VOLT_W-1:0] lvl,
                                     input logic signed [VOLT_W-1:0] smp,
                                     input logic [CH_W-1:0] ch, input logic last);
    int unsigned     rl;
    int unsigned     wp;
    int unsigned     dly;
    int unsigned     rp;
    int unsigned     minb;
    int unsigned     key;
    int unsigned     frac;
    longint unsigned span;
    bit              fire;
    tap_t            tap;
    rl   = active_length();
    fire = 1'b0;
    if (ch == 0) begin
      if (elapsed != ELAPSED_MAX) elapsed++;
      if (!armed_low) begin
        if (lvl <= trig_low) armed_low = 1'b1;
      end else if (lvl >= trig_high) begin
        armed_low = 1'b0;
        fire      = 1'b1;
      end
      if (fire) begin
        if (clock_seen) begin
          minb = (rl - 1 + MIN_BEAT_HALF) / MIN_BEAT_DIV;
          beat = (elapsed > minb) ? elapsed : BEAT_W'(minb);
        end
        clock_seen = 1'b1;
        elapsed    = '0;
      end
      frac = (fraction > FRAC_MAX) ? FRAC_MAX : fraction;
      span = 64'(beat);
      span = (span * frac + 8) >> 4;
      if (span > rl - 1) span = rl - 1;
      cur_delay = POS_W'(span);
    end
    wp  = (wr_pos >= rl) ? 0 : wr_pos;
    dly = (cur_delay > rl - 1) ? rl - 1 : cur_delay;
    rp  = (wp >= dly) ? wp - dly : wp + rl - dly;
    tap.delayed_sample = '0;
    tap.channel        = ch;
    if (ch < CHANNELS) begin
      key = ch * RING_DEPTH;
      lanes[key + wp] = smp;
      if (lanes.exists(key + rp)) tap.delayed_sample = lanes[key + rp];
    end
    if (last) begin
      wp++;
      if (wp >= rl) wp = 0;
      wr_pos = POS_W'(wp);
    end
    return tap;
  endfunction

  always @(posedge clk_i) begin
    tap_t got;
    tap_t want;
    if (!rst_ni) begin
      fraction     = FRAC_W'(FRAC_RESET);
      ring_length  = LEN_W'(RING_LENGTH_RESET);
      initial_beat = BEAT_W'(INIT_BEAT_RESET);
      trig_high    = VOLT_W'(TRIG_HIGH_RESET);
      trig_low     = VOLT_W'(TRIG_LOW_RESET);
      lanes.delete();
      wr_pos       = '0;
      elapsed      = '0;
      beat         = initial_beat;
      clock_seen   = 1'b0;
      armed_low    = 1'b0;
      cur_delay    = '0;
      due_taps.delete();
      mismatches_o = 0;
      reported     = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.delayed_sample = result_i.delayed_sample;
        got.channel        = result_i.channel_out;
        if (due_taps.size() == 0) begin
          mismatches_o++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t: unexpected item: sample %0d channel %0d", $realtime,
                     got.delayed_sample, got.channel);
          end
        end else begin
          want = due_taps.pop_front();
          if (got.delayed_sample !== want.delayed_sample || got.channel !== want.channel) begin
            mismatches_o++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("%0t: mismatch: expected sample %0d channel %0d, got sample %0d channel %0d",
                       $realtime, want.delayed_sample, want.channel,
                       got.delayed_sample, got.channel);
            end
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_FRACTION:     fraction = cfg_i.data[FRAC_W-1:0];
          REG_RING_LENGTH: begin
            ring_length = cfg_i.data[LEN_W-1:0];
            wr_pos      = '0;
          end
          REG_INITIAL_BEAT: initial_beat = cfg_i.data[BEAT_W-1:0];
          REG_TRIG_HIGH:    trig_high = cfg_i.data[VOLT_W-1:0];
          REG_TRIG_LOW:     trig_low = cfg_i.data[VOLT_W-1:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        due_taps.push_back(delay_tap(item_i.clock_level, item_i.sample_in,
                                     item_i.channel, item_i.frame_last));
      end
    end
    in_flight_o = due_taps.size();
  end

endmodule

FILE: test/clock_synced_fraction_delay_tb.sv
`timescale 1ns / 1ps
module clock_synced_fraction_delay_tb;
  import csfd_pkg::*;

  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 210;
  localparam int LATENCY        = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_PHASE     = 6;
  localparam int WATCHDOG_LIMIT = 1600000;
  localparam int VOLT_MAX       = 32767;
  localparam int VOLT_MIN       = -32768;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int tx_idle_pct  = 29;
  int rx_idle_pct  = 87;
  bit rx_hold_req  = 1'b0;
  int hi_lvl       = TRIG_HIGH_RESET;
  int lo_lvl       = TRIG_LOW_RESET;
  int beat_frames  = 4;
  int frame_no     = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int mismatches;
  int in_flight;

  csfd_item_if   item_bus();
  csfd_result_if result_bus();
  csfd_cfg_if    cfg_bus();

  clock_synced_fraction_delay DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  clock_synced_fraction_delay_checker delay_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .item_i       (item_bus),
    .result_i     (result_bus),
    .mismatches_o (mismatches),
    .in_flight_o  (in_flight)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [VOLT_W-1:0] clock_sample();
    int lvl;
    if ($urandom_range(99) < 8) return VOLT_W'($urandom);
    if ((frame_no % beat_frames) < (beat_frames + 1) / 2) begin
      lvl = hi_lvl + int'($urandom_range(0, VOLT_MAX - hi_lvl));
    end else begin
      lvl = VOLT_MIN + int'($urandom_range(0, lo_lvl - VOLT_MIN));
    end
    return VOLT_W'(lvl);
  endfunction

  task automatic push_item(input logic [VOLT_W-1:0] lvl, input logic [VOLT_W-1:0] smp,
                           input logic [CH_W-1:0] ch, input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    item_bus.valid       <= 1'b1;
    item_bus.clock_level <= lvl;
    item_bus.sample_in   <= smp;
    item_bus.channel     <= ch;
    item_bus.frame_last  <= last;
    do @(posedge clk_i); while (!item_bus.ready);
    items_sent++;
  endtask

  task automatic send_frame(input int n_ch, input bit closed);
    for (int c = 0; c < n_ch; c++) begin
      push_item((c == 0) ? clock_sample() : VOLT_W'($urandom), VOLT_W'($urandom),
                CH_W'(c), closed && (c == n_ch - 1));
    end
    frame_no++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic write_settings(input int frac, input int ring, input int beat,
                                input int hi, input int lo);
    write_reg(REG_FRACTION, CFG_DATA_W'(frac));
    write_reg(REG_RING_LENGTH, CFG_DATA_W'(ring));
    write_reg(REG_INITIAL_BEAT, CFG_DATA_W'(beat));
    write_reg(REG_TRIG_HIGH, {{(CFG_DATA_W - VOLT_W){1'b0}}, VOLT_W'(hi)});
    write_reg(REG_TRIG_LOW, {{(CFG_DATA_W - VOLT_W){1'b0}}, VOLT_W'(lo)});
    cfg_bus.valid <= 1'b0;
    hi_lvl = hi;
    lo_lvl = lo;
  endtask

  // wait for every outstanding item to come back
  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    int frac_v;
    int ring_v;
    int beat_v;
    int hi_v;
    int lo_v;
    int target;
    int roll;
    item_bus.valid       = 1'b0;
    item_bus.clock_level = '0;
    item_bus.sample_in   = '0;
    item_bus.channel     = '0;
    item_bus.frame_last  = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, full-scale samples; trigger not yet armed
    for (int c = 0; c < CHANNELS; c++) begin
      push_item(16'h7FFF, c[0] ? 16'h8000 : 16'h7FFF, CH_W'(c), c == CHANNELS - 1);
    end
    settle();

    // zero ring length, fraction above sixteen, trigger at the rails
    write_settings((1 << FRAC_W) - 1, 0, (1 << BEAT_W) - 1, VOLT_MAX, VOLT_MIN);
    push_item(16'h8000, 16'h1234, '0, 1'b1);
    push_item(16'h7FFF, 16'hEDCB, '0, 1'b1);
    push_item(16'h8000, 16'h7FFF, '0, 1'b1);
    push_item(16'h7FFF, 16'h8000, '0, 1'b1);
    push_item(16'h0000, 16'hFFFF, CH_W'(CHANNELS - 1), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      tx_idle_pct = (p < 3) ? 29 : (p < 6) ? 87 : 0;
      rx_idle_pct = (p < 3) ? 87 : (p < 6) ? 29 : 0;
      frac_v = (p == 0) ? 0 : (p == 1) ? FRAC_MAX : (p == 2) ? (1 << FRAC_W) - 1 :
               $urandom_range(0, (1 << FRAC_W) - 1);
      case (p)
        3:       ring_v = RING_DEPTH;
        4:       ring_v = (1 << LEN_W) - 1;
        5:       ring_v = RING_LENGTH_RESET;
        7:       ring_v = 1;
        default: ring_v = $urandom_range(2, 96);
      endcase
      beat_v = (p == 0) ? 1 : (p == 1) ? (1 << BEAT_W) - 1 : $urandom_range(1, (1 << BEAT_W) - 1);
      if (p == 2) begin
        hi_v = VOLT_MIN;
        lo_v = VOLT_MAX;
      end else if (p == 8) begin
        hi_v = VOLT_MAX;
        lo_v = VOLT_MIN;
      end else begin
        hi_v = 1000 + int'($urandom_range(0, 19000));
        lo_v = hi_v - int'($urandom_range(1, 20000));
      end
      write_settings(frac_v, ring_v, beat_v, hi_v, lo_v);
      beat_frames = $urandom_range(2, 12);
      if (p == HOLD_PHASE) rx_hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          push_item(VOLT_W'($urandom), VOLT_W'($urandom), CH_W'($urandom), 1'($urandom));
        end else if (roll < 10) begin
          send_frame($urandom_range(1, CHANNELS), 1'b0);
        end else begin
          send_frame((roll < 55) ? CHANNELS : $urandom_range(1, CHANNELS), 1'b1);
        end
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
